// ===== rtl/sha_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 engine.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package sha_pkg;

   localparam int WordBits    = 32;
   localparam int HashWords   = 8;
   localparam int BlockWords  = 16;
   localparam int Rounds      = 64;
   localparam int LengthBits  = 64;
   localparam int CountBits   = $clog2(BlockWords);
   localparam int RoundBits   = $clog2(Rounds);
   localparam int IndexBits   = $clog2(HashWords);
   localparam int LenIncBits  = 6;   // holds up to 32 bits per word

   typedef logic [WordBits-1:0] word_type;

   localparam word_type PadMark = 32'h8000_0000;

   localparam word_type InitHash [HashWords] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type RoundConst [Rounds] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // Source of the word shifted into the schedule window
   typedef enum logic [2:0] {
      PUSH_INPUT,
      PUSH_TAIL,
      PUSH_MARK,
      PUSH_ZERO,
      PUSH_LEN_HI,
      PUSH_LEN_LO
   } push_sel_type;

   typedef struct packed {
      logic                  push;
      push_sel_type          push_sel;
      logic                  len_add;
      logic [LenIncBits-1:0] len_inc;
      logic                  load_work;
      logic                  round;
      logic [RoundBits-1:0]  round_idx;
      logic                  update;
      logic                  restart;
      logic [IndexBits-1:0]  digest_idx;
   } dp_cmd_type;

   function automatic word_type rotr(input word_type x, input int n);
      rotr = (x >> n) | (x << (WordBits - n));
   endfunction

   function automatic word_type small_sig0(input word_type x);
      small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_sig1(input word_type x);
      small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic word_type big_sig0(input word_type x);
      big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type big_sig1(input word_type x);
      big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/sha_dp.sv =====
// SHA-256 datapath: schedule window, working variables, hash words, bit length.
// Driven by command structure from sha_ctrl; uses sha_pkg.
`default_nettype none

module sha_dp
   import sha_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire dp_cmd_type cmd,
   input  wire word_type   req_message_word,
   input  wire logic [2:0] req_valid_bytes,
   output      word_type   rsp_digest_word
);

   word_type               win_ff  [BlockWords];
   word_type               win_in  [BlockWords];
   word_type               work_ff [HashWords];
   word_type               work_in [HashWords];
   word_type               hash_ff [HashWords];
   word_type               hash_in [HashWords];
   logic [LengthBits-1:0]  len_ff;
   logic [LengthBits-1:0]  len_in;

   word_type push_word;
   word_type tail_word;
   word_type next_sched;
   word_type t1;
   word_type t2;
   word_type ch;
   word_type maj;

   // Last word with fewer than four bytes: clear unused bytes, add the one bit
   always_comb begin
      unique case (req_valid_bytes[1:0])
         2'd1:    tail_word = {req_message_word[31:24], 8'h80, 16'h0000};
         2'd2:    tail_word = {req_message_word[31:16], 8'h80, 8'h00};
         2'd3:    tail_word = {req_message_word[31:8], 8'h80};
         default: tail_word = PadMark;
      endcase
   end

   always_comb begin
      unique case (cmd.push_sel)
         PUSH_INPUT:  push_word = req_message_word;
         PUSH_TAIL:   push_word = tail_word;
         PUSH_MARK:   push_word = PadMark;
         PUSH_LEN_HI: push_word = len_ff[LengthBits-1:WordBits];
         PUSH_LEN_LO: push_word = len_ff[WordBits-1:0];
         default:     push_word = '0;
      endcase
   end

   // Window holds W[t..t+15] at round t
   assign next_sched = small_sig1(win_ff[14]) + win_ff[9] + small_sig0(win_ff[1]) + win_ff[0];

   assign ch  = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
   assign maj = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
              ^ (work_ff[1] & work_ff[2]);
   assign t1  = work_ff[7] + big_sig1(work_ff[4]) + ch + RoundConst[cmd.round_idx] + win_ff[0];
   assign t2  = big_sig0(work_ff[0]) + maj;

   always_comb begin
      for (int i = 0; i < BlockWords; i++) begin
         win_in[i] = win_ff[i];
      end
      if (cmd.push || cmd.round) begin
         for (int i = 0; i < BlockWords - 1; i++) begin
            win_in[i] = win_ff[i+1];
         end
         win_in[BlockWords-1] = cmd.push ? push_word : next_sched;
      end
   end

   always_comb begin
      for (int i = 0; i < HashWords; i++) begin
         work_in[i] = work_ff[i];
      end
      if (cmd.load_work) begin
         for (int i = 0; i < HashWords; i++) begin
            work_in[i] = hash_ff[i];
         end
      end else if (cmd.round) begin
         for (int i = 1; i < HashWords; i++) begin
            work_in[i] = work_ff[i-1];
         end
         work_in[4] = work_ff[3] + t1;
         work_in[0] = t1 + t2;
      end
   end

   always_comb begin
      for (int i = 0; i < HashWords; i++) begin
         if (cmd.restart) begin
            hash_in[i] = InitHash[i];
         end else if (cmd.update) begin
            hash_in[i] = hash_ff[i] + work_ff[i];
         end else begin
            hash_in[i] = hash_ff[i];
         end
      end
      if (cmd.restart) begin
         len_in = '0;
      end else if (cmd.len_add) begin
         len_in = len_ff + {{(LengthBits-LenIncBits){1'b0}}, cmd.len_inc};
      end else begin
         len_in = len_ff;
      end
   end

   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      work_ff <= work_in;
      if (reset) begin
         hash_ff <= InitHash;
         len_ff  <= '0;
      end else begin
         hash_ff <= hash_in;
         len_ff  <= len_in;
      end
   end

   assign rsp_digest_word = hash_ff[cmd.digest_idx];

endmodule

`default_nettype wire

// ===== rtl/sha_ctrl.sv =====
// SHA-256 controller: word collection, padding sequence, round count, digest output.
// Issues dp_cmd_type commands to sha_dp; uses sha_pkg.
`default_nettype none

module sha_ctrl
   import sha_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire logic [2:0] req_valid_bytes,
   input  wire logic       req_last_word,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      logic [IndexBits-1:0] rsp_digest_index,
   output      logic       rsp_digest_last,
   output      dp_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_COLLECT,
      S_PAD,
      S_ROUND,
      S_UPDATE,
      S_EMIT
   } state_type;

   typedef enum logic [1:0] {
      P_MARK,
      P_ZERO,
      P_LEN_LO,
      P_DONE
   } pad_step_type;

   localparam logic [CountBits-1:0] LastSlot   = CountBits'(BlockWords - 1);
   localparam logic [CountBits-1:0] LenSlot    = CountBits'(BlockWords - 2);
   localparam logic [RoundBits-1:0] LastRound  = RoundBits'(Rounds - 1);
   localparam logic [IndexBits-1:0] LastIndex  = IndexBits'(HashWords - 1);
   localparam logic [LenIncBits-1:0] FullWordBits = LenIncBits'(WordBits);

   state_type            state_ff,  state_in;
   pad_step_type         pad_ff,    pad_in;
   logic                 padding_ff, padding_in;
   logic [CountBits-1:0] count_ff,  count_in;
   logic [RoundBits-1:0] round_ff,  round_in;
   logic [IndexBits-1:0] idx_ff,    idx_in;
   logic [2:0]           bytes_sat;

   assign bytes_sat = (req_valid_bytes > 3'd4) ? 3'd4 : req_valid_bytes;

   always_comb begin
      state_in   = state_ff;
      pad_in     = pad_ff;
      padding_in = padding_ff;
      count_in   = count_ff;
      round_in   = round_ff;
      idx_in     = idx_ff;
      cmd        = '0;
      cmd.push_sel   = PUSH_ZERO;
      cmd.round_idx  = round_ff;
      cmd.digest_idx = idx_ff;

      unique case (state_ff)
         S_COLLECT: begin
            if (req_valid) begin
               cmd.push    = 1'b1;
               cmd.len_add = 1'b1;
               if (!req_last_word) begin
                  cmd.push_sel = PUSH_INPUT;
                  cmd.len_inc  = FullWordBits;
               end else begin
                  padding_in  = 1'b1;
                  state_in    = S_PAD;
                  cmd.len_inc = {bytes_sat, 3'b000};
                  if (bytes_sat == 3'd4) begin
                     cmd.push_sel = PUSH_INPUT;
                     pad_in       = P_MARK;
                  end else begin
                     cmd.push_sel = PUSH_TAIL;
                     pad_in       = P_ZERO;
                  end
               end
            end
         end
         S_PAD: begin
            unique case (pad_ff)
               P_MARK: begin
                  cmd.push     = 1'b1;
                  cmd.push_sel = PUSH_MARK;
                  pad_in       = P_ZERO;
               end
               P_ZERO: begin
                  cmd.push = 1'b1;
                  if (count_ff == LenSlot) begin
                     cmd.push_sel = PUSH_LEN_HI;
                     pad_in       = P_LEN_LO;
                  end else begin
                     cmd.push_sel = PUSH_ZERO;
                  end
               end
               P_LEN_LO: begin
                  cmd.push     = 1'b1;
                  cmd.push_sel = PUSH_LEN_LO;
                  pad_in       = P_DONE;
               end
               default: state_in = S_EMIT;
            endcase
         end
         S_ROUND: begin
            cmd.round = 1'b1;
            round_in  = round_ff + 1'b1;
            if (round_ff == LastRound) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            if (!padding_ff) begin
               state_in = S_COLLECT;
            end else if (pad_ff == P_DONE) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_PAD;
            end
         end
         S_EMIT: begin
            if (!rsp_stall) begin
               idx_in = idx_ff + 1'b1;
               if (idx_ff == LastIndex) begin
                  cmd.restart = 1'b1;
                  padding_in  = 1'b0;
                  state_in    = S_COLLECT;
               end
            end
         end
         default: state_in = S_COLLECT;
      endcase

      // Sixteenth word of a block starts a compression
      if (cmd.push) begin
         count_in = count_ff + 1'b1;
         if (count_ff == LastSlot) begin
            cmd.load_work = 1'b1;
            round_in      = '0;
            state_in      = S_ROUND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_COLLECT;
         pad_ff     <= P_MARK;
         padding_ff <= 1'b0;
         count_ff   <= '0;
         round_ff   <= '0;
         idx_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         pad_ff     <= pad_in;
         padding_ff <= padding_in;
         count_ff   <= count_in;
         round_ff   <= round_in;
         idx_ff     <= idx_in;
      end
   end

   assign req_stall        = (state_ff != S_COLLECT);
   assign rsp_valid        = (state_ff == S_EMIT);
   assign rsp_digest_index = idx_ff;
   assign rsp_digest_last  = (idx_ff == LastIndex);

endmodule

`default_nettype wire

// ===== rtl/sha256_hash_engine_top.sv =====
// SHA-256 engine: one word accepted per cycle while a block fills, then a
// round loop plus one hash update per 16-word block. The last word adds
// padding words and one or two compressions, then eight digest transactions.
// Synchronous active-high reset: controller idle, hash words to initial values,
// bit length cleared. No clearing pass; the engine accepts words after reset.
`default_nettype none

module sha256_hash_engine_top
   import sha_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [31:0] req_message_word,
   input  wire logic [2:0]  req_valid_bytes,
   input  wire logic        req_last_word,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [31:0] rsp_digest_word,
   output      logic [2:0]  rsp_digest_index,
   output      logic        rsp_digest_last
);

   dp_cmd_type cmd;

   sha_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_valid_bytes  (req_valid_bytes),
      .req_last_word    (req_last_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_digest_index (rsp_digest_index),
      .rsp_digest_last  (rsp_digest_last),
      .cmd              (cmd)
   );

   sha_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_message_word (req_message_word),
      .req_valid_bytes  (req_valid_bytes),
      .rsp_digest_word  (rsp_digest_word)
   );

endmodule

`default_nettype wire

// ===== rtl/sha_chk.sv =====
// Port-level checks for sha256_hash_engine_top, attached by bind.
// Sees only the top-level ports; no package dependency.
`default_nettype none

module sha_chk (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        req_last_word,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_digest_word,
   input wire logic [2:0]  rsp_digest_index,
   input wire logic        rsp_digest_last
);

   // No input transaction while the digest is being delivered
   a_no_req_during_digest: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input accepted while digest pending");

   // Digest words come out in order without gaps
   a_index_steps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_digest_last) |=>
         (rsp_valid && rsp_digest_index == 3'($past(rsp_digest_index) + 3'd1)))
      else $error("digest index did not advance");

   // The final word of a message always starts padding, so input stalls
   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_last_word) |=> req_stall)
      else $error("input not stalled after last word");

   // After the eighth digest word the result channel goes quiet
   a_quiet_after_digest: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_digest_last) |=> !rsp_valid)
      else $error("result valid after final digest word");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_digest_word) && $stable(rsp_digest_index)))
      else $error("stalled digest word changed");

endmodule

bind sha256_hash_engine_top sha_chk u_sha_chk (.*);

`default_nettype wire

// ===== sim/sha256_hash_engine_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sha256_hash_engine_top: whole messages in, digest words out.
// Depends on sha_pkg and the engine RTL; carries its own SHA-256 digest predictor.

module sha256_hash_engine_top_test;
   import sha_pkg::word_type;

   localparam int CycleLimit   = 400000;
   localparam int WordBytes    = 4;
   localparam int HoldCycles   = 600;
   localparam int HoldAfter    = 16;
   localparam int SettleCycles = 200;
   localparam int RandomItems  = 260;

   localparam word_type MarkWord = 32'h8000_0000;

   localparam word_type IvTable [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type KTable [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef struct {
      word_type   word;
      logic [2:0] vbytes;
      logic       last;
      bit         drain;   // hold back until every outstanding digest is out
   } msg_word_type;

   typedef struct {
      word_type   word;
      logic [2:0] index;
      logic       last;
   } digest_type;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_message_word = '0;
   logic [2:0]  req_valid_bytes = '0;
   logic        req_last_word = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_digest_index;
   logic        rsp_digest_last;

   msg_word_type pending_words[$];
   digest_type   digest_due[$];
   int          total_words;
   int          words_taken = 0;
   int          digests_seen = 0;
   int          mismatch_count = 0;
   int          cycle_count = 0;

   // predictor state
   word_type    chain[8];
   word_type    blk[16];
   logic [63:0] msg_bits;
   int          fill;

   sha256_hash_engine_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_message_word (req_message_word),
      .req_valid_bytes  (req_valid_bytes),
      .req_last_word    (req_last_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_digest_word  (rsp_digest_word),
      .rsp_digest_index (rsp_digest_index),
      .rsp_digest_last  (rsp_digest_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic word_type ror32(word_type x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type sched_s0(word_type x);
      return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type sched_s1(word_type x);
      return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
   endfunction

   function automatic word_type mix_a(word_type x);
      return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
   endfunction

   function automatic word_type mix_e(word_type x);
      return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
   endfunction

   task automatic fold_block();
      word_type w[64];
      word_type v[8];
      word_type t1, t2;
      for (int i = 0; i < 16; i++)
         w[i] = blk[i];
      for (int i = 16; i < 64; i++)
         w[i] = sched_s1(w[i-2]) + w[i-7] + sched_s0(w[i-15]) + w[i-16];
      v = chain;
      for (int r = 0; r < 64; r++) begin
         t1 = v[7] + mix_e(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTable[r] + w[r];
         t2 = mix_a(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         for (int i = 7; i > 0; i--)
            v[i] = v[i-1];
         v[4] = v[4] + t1;
         v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++)
         chain[i] = chain[i] + v[i];
   endtask

   task automatic absorb(word_type w);
      blk[fill] = w;
      fill++;
      if (fill == 16) begin
         fold_block();
         fill = 0;
      end
   endtask

   task automatic restart_digest();
      chain = IvTable;
      msg_bits = '0;
      fill = 0;
   endtask

   task automatic predict_word(word_type word, logic [2:0] vb_in, logic last);
      int vb;
      digest_type d;
      vb = (vb_in > WordBytes) ? WordBytes : vb_in;
      if (!last) begin
         // byte count only matters on the final word
         msg_bits += 32;
         absorb(word);
      end else begin
         msg_bits += 8 * vb;
         if (vb == WordBytes) begin
            absorb(word);
            absorb(MarkWord);
         end else if (vb == 0)
            absorb(MarkWord);
         else
            absorb((word & (32'hFFFF_FFFF << (32 - 8 * vb))) | (32'h80 << (24 - 8 * vb)));
         while (fill != 14)
            absorb('0);
         absorb(msg_bits[63:32]);
         absorb(msg_bits[31:0]);
         for (int k = 0; k < 8; k++) begin
            d.word  = chain[k];
            d.index = k[2:0];
            d.last  = (k == 7);
            digest_due.insert(digest_due.size(), d);
         end
         restart_digest();
      end
   endtask

   task automatic queue_word(word_type w, logic [2:0] vb, logic last, bit drain);
      msg_word_type m;
      m.word   = w;
      m.vbytes = vb;
      m.last   = last;
      m.drain  = drain;
      pending_words.insert(pending_words.size(), m);
   endtask

   task automatic queue_message(int body, logic [2:0] last_vb, bit drain);
      for (int i = 0; i < body; i++)
         queue_word($urandom, 3'($urandom_range(0, 7)), 1'b0, drain && i == 0);
      queue_word($urandom, last_vb, 1'b1, drain && body == 0);
   endtask

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("%0t: %s mismatch: got %h want %h", $time, field, got, want);
      mismatch_count++;
   endtask

   // driver: bursts of transactions with random gaps
   int gap_left = 0;
   int burst_left = 0;

   always @(posedge clock) begin : driver
      msg_word_type nxt;
      bit offer;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
         burst_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_word(req_message_word, req_valid_bytes, req_last_word);
            words_taken++;
         end
         if (!req_valid || !req_stall) begin
            offer = 1'b0;
            if (gap_left > 0)
               gap_left--;
            else if (pending_words.size() != 0
                     && !(pending_words[0].drain && digest_due.size() != 0)) begin
               nxt = pending_words.pop_front();
               offer = 1'b1;
               req_message_word <= nxt.word;
               req_valid_bytes  <= nxt.vbytes;
               req_last_word    <= nxt.last;
               if (burst_left > 0)
                  burst_left--;
               else begin
                  burst_left = $urandom_range(0, 30);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
            req_valid <= offer;
         end
      end
   end

   // receiver stall pattern, with one long hold-off early on
   stall_mode_type stall_mode = STALL_NONE;
   int mode_left = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && digests_seen >= HoldAfter) begin
         hold_done = 1'b1;
         hold_left = HoldCycles;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(16, 96);
         end else
            mode_left--;
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= ((cycle_count % 5) < 2);
         endcase
      end
   end

   always @(posedge clock) begin : monitor
      digest_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         digests_seen++;
         if (digest_due.size() == 0)
            report_mismatch("unexpected digest transaction", rsp_digest_word, '0);
         else begin
            want = digest_due.pop_front();
            if (rsp_digest_word !== want.word)
               report_mismatch("digest_word", rsp_digest_word, want.word);
            if (rsp_digest_index !== want.index)
               report_mismatch("digest_index", 32'(rsp_digest_index), 32'(want.index));
            if (rsp_digest_last !== want.last)
               report_mismatch("digest_last", 32'(rsp_digest_last), 32'(want.last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin : stimulus
      int body, sel, count;
      logic [2:0] last_vb;
      restart_digest();

      // directed: empty message, short tails, oversize byte counts
      queue_word('1, 3'd0, 1'b1, 1'b0);
      queue_word('1, 3'd1, 1'b1, 1'b0);
      queue_word('0, 3'd2, 1'b1, 1'b0);
      queue_word($urandom, 3'd3, 1'b1, 1'b0);
      queue_word('1, 3'd4, 1'b1, 1'b0);
      queue_word($urandom, 3'd5, 1'b1, 1'b0);
      queue_word($urandom, 3'd7, 1'b1, 1'b0);
      queue_word('0, 3'd0, 1'b0, 1'b0);
      queue_word('1, 3'd6, 1'b1, 1'b0);
      // 14 full words plus one byte: padding spills into a further block
      for (int i = 0; i < 14; i++)
         queue_word((i % 2) ? '1 : '0, 3'($urandom_range(0, 7)), 1'b0, i == 0);
      queue_word($urandom, 3'd1, 1'b1, 1'b0);

      count = pending_words.size();
      while (count < RandomItems) begin
         sel = $urandom_range(0, 99);
         if (sel < 40)
            body = $urandom_range(0, 3);
         else if (sel < 70)
            body = $urandom_range(12, 17);
         else if (sel < 85)
            body = $urandom_range(28, 33);
         else
            body = $urandom_range(0, 40);
         last_vb = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4));
         queue_message(body, last_vb, $urandom_range(0, 5) == 0);
         count += body + 1;
      end
      total_words = pending_words.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (words_taken < total_words || digest_due.size() != 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);

      if (mismatch_count == 0 && digest_due.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
